// ===== src/source_text_tokenizer_defines.svh =====
// Assertion macros for the source text tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define STT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define STT_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define STT_ASSERT(label, clk, rstn, prop)
`define STT_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== src/stt_pkg.sv =====
// Types, token codes and keyword lookup for the source text tokenizer.
package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_IDENT  = 4'd1,
        M_NUM    = 4'd2,
        M_NUMDOT = 4'd3,
        M_FRAC   = 4'd4,
        M_STR    = 4'd5,
        M_CMT    = 4'd6,
        M_SLASH  = 4'd7,
        M_OP     = 4'd8
    } scan_mode_t;

    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_SEMI     = 6'd4;
    localparam logic [5:0] K_COLON    = 6'd5;
    localparam logic [5:0] K_COMMA    = 6'd6;
    localparam logic [5:0] K_DOT      = 6'd7;
    localparam logic [5:0] K_MINUS    = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd10;
    localparam logic [5:0] K_SLASH    = 6'd12;
    localparam logic [5:0] K_SLASH_EQ = 6'd13;
    localparam logic [5:0] K_STAR     = 6'd14;
    localparam logic [5:0] K_PERCENT  = 6'd16;
    localparam logic [5:0] K_BANG     = 6'd18;
    localparam logic [5:0] K_EQUAL    = 6'd20;
    localparam logic [5:0] K_LESS     = 6'd22;
    localparam logic [5:0] K_GREATER  = 6'd24;
    localparam logic [5:0] K_IDENT    = 6'd26;
    localparam logic [5:0] K_STRING   = 6'd27;
    localparam logic [5:0] K_NUMBER   = 6'd28;
    localparam logic [5:0] K_AND      = 6'd29;
    localparam logic [5:0] K_BREAK    = 6'd30;
    localparam logic [5:0] K_CASE     = 6'd31;
    localparam logic [5:0] K_CLASS    = 6'd32;
    localparam logic [5:0] K_CONTINUE = 6'd33;
    localparam logic [5:0] K_DEFAULT  = 6'd34;
    localparam logic [5:0] K_ELSE     = 6'd35;
    localparam logic [5:0] K_FALSE    = 6'd36;
    localparam logic [5:0] K_FOR      = 6'd37;
    localparam logic [5:0] K_FUN      = 6'd38;
    localparam logic [5:0] K_IF       = 6'd39;
    localparam logic [5:0] K_NIL      = 6'd40;
    localparam logic [5:0] K_OR       = 6'd41;
    localparam logic [5:0] K_PRINT    = 6'd42;
    localparam logic [5:0] K_RETURN   = 6'd43;
    localparam logic [5:0] K_SUPER    = 6'd44;
    localparam logic [5:0] K_SWITCH   = 6'd45;
    localparam logic [5:0] K_THIS     = 6'd46;
    localparam logic [5:0] K_TRUE     = 6'd47;
    localparam logic [5:0] K_VAR      = 6'd48;
    localparam logic [5:0] K_WHILE    = 6'd49;
    localparam logic [5:0] K_EOF      = 6'd50;
    localparam logic [5:0] K_ERR_CHAR = 6'd51;
    localparam logic [5:0] K_ERR_STR  = 6'd52;

    localparam int MAX_RES = 3;

    // One result item: kind, start, length, line.
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } token_t;

    // Up to three results that one input item causes.
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } result_set_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c);
        case (c)
            8'h2d:   return K_MINUS;
            8'h2b:   return K_PLUS;
            8'h2f:   return K_SLASH;
            8'h2a:   return K_STAR;
            8'h25:   return K_PERCENT;
            8'h21:   return K_BANG;
            8'h3d:   return K_EQUAL;
            8'h3c:   return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    // Match the first eight prefix bytes against the keyword list; w is
    // packed with byte 0 in the top bits, unused tail bytes ignored by length.
    function automatic logic [5:0] keyword_kind(input logic [63:0] w, input logic [3:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            4'd2: begin
                if (w[63:48] == "if") k = K_IF;
                if (w[63:48] == "or") k = K_OR;
            end
            4'd3: begin
                if (w[63:40] == "and") k = K_AND;
                if (w[63:40] == "for") k = K_FOR;
                if (w[63:40] == "fun") k = K_FUN;
                if (w[63:40] == "nil") k = K_NIL;
                if (w[63:40] == "var") k = K_VAR;
            end
            4'd4: begin
                if (w[63:32] == "case") k = K_CASE;
                if (w[63:32] == "else") k = K_ELSE;
                if (w[63:32] == "this") k = K_THIS;
                if (w[63:32] == "true") k = K_TRUE;
            end
            4'd5: begin
                if (w[63:24] == "break") k = K_BREAK;
                if (w[63:24] == "class") k = K_CLASS;
                if (w[63:24] == "false") k = K_FALSE;
                if (w[63:24] == "print") k = K_PRINT;
                if (w[63:24] == "super") k = K_SUPER;
                if (w[63:24] == "while") k = K_WHILE;
            end
            4'd6: begin
                if (w[63:16] == "return") k = K_RETURN;
                if (w[63:16] == {"sw", "itch"}) k = K_SWITCH;
            end
            4'd7: begin
                if (w[63:8] == {"d", "efault"}) k = K_DEFAULT;
            end
            4'd8: begin
                if (w == {"co", "ntinue"}) k = K_CONTINUE;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== src/stt_out_queue.sv =====
// Output queue that spreads a set of up to three tokens over the result channel.
module stt_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  stt_pkg::result_set_t set_in,
    output logic                 can_push,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output stt_pkg::token_t      m_tok,
    output logic                 m_last
);
    import stt_pkg::*;

    `include "source_text_tokenizer_defines.svh"

    // Two set slots; each slot delivers its tokens one by one.
    result_set_t slot_reg [2];
    logic [1:0]  idx_reg;
    logic        rd_reg, wr_reg;
    logic [1:0]  fill_reg;
    logic        pop_tok, pop_set;
    result_set_t head;

    assign head     = slot_reg[rd_reg];
    assign m_tvalid = fill_reg != 2'd0;
    assign pop_tok  = m_tvalid && m_tready;
    assign pop_set  = pop_tok && (idx_reg + 2'd1 == head.count);
    assign m_last   = idx_reg + 2'd1 == head.count;
    assign can_push = fill_reg != 2'd2 || pop_set;

    always_comb begin
        case (idx_reg)
            2'd0:    m_tok = head.t0;
            2'd1:    m_tok = head.t1;
            default: m_tok = head.t2;
        endcase
    end

    // Store pushed sets; empty sets are never pushed.
    always_ff @(posedge aclk) begin
        if (push && can_push) slot_reg[wr_reg] <= set_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (push && can_push) wr_reg <= ~wr_reg;
            if (pop_set) begin
                rd_reg  <= ~rd_reg;
                idx_reg <= '0;
            end else if (pop_tok) begin
                idx_reg <= idx_reg + 2'd1;
            end
            fill_reg <= fill_reg + {1'b0, push && can_push} - {1'b0, pop_set};
        end
    end

    `STT_ASSERT(a_fill_max, aclk, aresetn, fill_reg != 2'd3)
    `STT_ASSERT(a_idx_in_set, aclk, aresetn, m_tvalid |-> idx_reg < head.count)
    `STT_ASSERT(a_no_push_full, aclk, aresetn, (push && fill_reg == 2'd2 && !pop_set) |-> !can_push)

endmodule

// ===== src/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
// Takes one source byte per item (or an end marker) and emits tokens of
// kind, start offset, length and line. A byte is accepted every cycle while
// the result queue has room; the scan step is one registered pass per byte.
// Items that produce several tokens (up to three) hand them to the result
// channel one at a time; the two-set output queue keeps taking bytes while
// earlier tokens wait, and stalls the input once both sets are held.
module source_text_tokenizer #(
    parameter int MAX_SOURCE_BYTES   = 65536,
    parameter int KEYWORD_PREFIX_LEN = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    input  logic        s_tuser,  // [0] end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // [5:0] token_kind, [21:6] start_offset,
                                  // [37:22] token_length, [53:38] line_number
    output logic        m_tlast   // last_of_run
);
    import stt_pkg::*;

    `include "source_text_tokenizer_defines.svh"

    localparam int CAP_I = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
    localparam logic [15:0] POS_CAP = 16'(CAP_I);
    localparam int PW = $clog2(KEYWORD_PREFIX_LEN);

    scan_mode_t  mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next, start_reg, start_next, line_reg, line_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  pre_reg [KEYWORD_PREFIX_LEN];
    logic        pre_we;
    logic [PW-1:0] pre_wa;
    logic [7:0]  pre_wd;

    result_set_t set;
    logic        can_push, accept;
    token_t      m_tok;

    assign s_tready = can_push;
    assign accept   = s_tvalid && s_tready;

    function automatic logic [15:0] adv(input logic [15:0] p);
        return (p < POS_CAP) ? p + 16'd1 : p;
    endfunction

    // Scan step: fold one byte or the end marker into the state.
    always_comb begin
        logic [7:0]  c;
        logic        redo;
        logic [15:0] len;
        logic [63:0] w;
        logic [5:0]  ik;
        c = s_tdata;
        mode_next = mode_reg; pos_next = pos_reg; start_next = start_reg;
        line_next = line_reg; held_next = held_reg;
        pre_we = 1'b0; pre_wa = '0; pre_wd = c;
        set = '0;
        redo = 1'b0;
        len = pos_reg - start_reg;
        w = '0;
        for (int i = 0; i < 8; i++) w[63-8*i -: 8] = pre_reg[i];
        ik = (len > 16'(KEYWORD_PREFIX_LEN) || len > 16'd8) ? K_IDENT :
             keyword_kind(w, len[3:0]);
        if (s_tuser) begin
            case (mode_reg)
                M_IDENT:       set.t0 = '{ik, start_reg, len, line_reg};
                M_NUM, M_FRAC: set.t0 = '{K_NUMBER, start_reg, len, line_reg};
                M_STR:         set.t0 = '{K_ERR_STR, start_reg, len, line_reg};
                M_SLASH:       set.t0 = '{K_SLASH, start_reg, len, line_reg};
                M_OP:          set.t0 = '{op_kind(held_reg), start_reg, len, line_reg};
                default:       set.t0 = '0;
            endcase
            if (mode_reg == M_NUMDOT) begin
                set.t0 = '{K_NUMBER, start_reg, len, line_reg};
                set.t1 = '{K_DOT, pos_reg, adv(pos_reg) - pos_reg, line_reg};
                set.t2 = '{K_EOF, adv(pos_reg), 16'd0, line_reg};
                set.count = 2'd3;
            end else if (mode_reg == M_IDLE || mode_reg == M_CMT) begin
                set.t0 = '{K_EOF, pos_reg, 16'd0, line_reg};
                set.count = 2'd1;
            end else begin
                set.t1 = '{K_EOF, pos_reg, 16'd0, line_reg};
                set.count = 2'd2;
            end
            mode_next = M_IDLE; pos_next = '0; start_next = '0;
            line_next = 16'd1; held_next = '0;
        end else begin
            case (mode_reg)
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (len < 16'(KEYWORD_PREFIX_LEN)) begin
                            pre_we = 1'b1; pre_wa = len[PW-1:0];
                        end
                        pos_next = adv(pos_reg);
                    end else begin
                        set.t0 = '{ik, start_reg, len, line_reg}; set.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(c)) pos_next = adv(pos_reg);
                    else if (c == 8'h2e) mode_next = M_NUMDOT;
                    else begin
                        set.t0 = '{K_NUMBER, start_reg, len, line_reg}; set.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(c)) begin
                        pos_next = adv(adv(pos_reg)); mode_next = M_FRAC;
                    end else begin
                        set.t0 = '{K_NUMBER, start_reg, len, line_reg};
                        set.t1 = '{K_DOT, pos_reg, adv(pos_reg) - pos_reg, line_reg};
                        set.count = 2'd2;
                        pos_next = adv(pos_reg); start_next = pos_reg;
                        redo = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) pos_next = adv(pos_reg);
                    else begin
                        set.t0 = '{K_NUMBER, start_reg, len, line_reg}; set.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_STR: begin
                    pos_next = adv(pos_reg);
                    if (c == 8'h22) begin
                        set.t0 = '{K_STRING, start_reg, pos_next - start_reg, line_reg};
                        set.count = 2'd1; mode_next = M_IDLE;
                    end else if (c == 8'h0a && line_reg != 16'hffff) begin
                        line_next = line_reg + 16'd1;
                    end
                end
                M_CMT: begin
                    if (c == 8'h0a) redo = 1'b1;
                    else pos_next = adv(pos_reg);
                end
                M_SLASH: begin
                    if (c == 8'h2f) begin
                        pos_next = adv(pos_reg); mode_next = M_CMT;
                    end else if (c == 8'h3d) begin
                        pos_next = adv(pos_reg); mode_next = M_IDLE;
                        set.t0 = '{K_SLASH_EQ, start_reg, pos_next - start_reg, line_reg};
                        set.count = 2'd1;
                    end else begin
                        set.t0 = '{K_SLASH, start_reg, len, line_reg}; set.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                M_OP: begin
                    if (c == 8'h3d) begin
                        pos_next = adv(pos_reg); mode_next = M_IDLE;
                        set.t0 = '{op_kind(held_reg) + 6'd1, start_reg,
                                   pos_next - start_reg, line_reg};
                        set.count = 2'd1;
                    end else begin
                        set.t0 = '{op_kind(held_reg), start_reg, len, line_reg};
                        set.count = 2'd1;
                        redo = 1'b1;
                    end
                end
                default: redo = 1'b1;
            endcase
            // Idle handling, also for the byte that ended a token.
            if (redo) begin
                logic [15:0] p;
                token_t      t;
                logic        hit;
                p = pos_next;
                mode_next = M_IDLE;
                hit = 1'b1;
                t = '0;
                if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
                    pos_next = adv(p); hit = 1'b0;
                end else if (c == 8'h0a) begin
                    if (line_reg != 16'hffff) line_next = line_reg + 16'd1;
                    pos_next = adv(p); hit = 1'b0;
                end else begin
                    start_next = p; pos_next = adv(p);
                    hit = 1'b0;
                    if (is_alpha(c)) begin
                        pre_we = 1'b1; pre_wa = '0; mode_next = M_IDENT;
                    end else if (is_digit(c)) begin
                        mode_next = M_NUM;
                    end else begin
                        case (c)
                            8'h22: mode_next = M_STR;
                            8'h2f: mode_next = M_SLASH;
                            8'h2d, 8'h2b, 8'h2a, 8'h25, 8'h21, 8'h3d, 8'h3c, 8'h3e: begin
                                held_next = c; mode_next = M_OP;
                            end
                            default: begin
                                hit = 1'b1;
                                case (c)
                                    8'h28:   t.kind = K_LPAREN;
                                    8'h29:   t.kind = K_RPAREN;
                                    8'h7b:   t.kind = K_LBRACE;
                                    8'h7d:   t.kind = K_RBRACE;
                                    8'h3b:   t.kind = K_SEMI;
                                    8'h3a:   t.kind = K_COLON;
                                    8'h2c:   t.kind = K_COMMA;
                                    8'h2e:   t.kind = K_DOT;
                                    default: t.kind = K_ERR_CHAR;
                                endcase
                                t.start = p; t.len = pos_next - p; t.line = line_next;
                            end
                        endcase
                    end
                end
                if (hit) begin
                    case (set.count)
                        2'd0:    set.t0 = t;
                        2'd1:    set.t1 = t;
                        default: set.t2 = t;
                    endcase
                    set.count = set.count + 2'd1;
                end
            end
        end
    end

    // Scan state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= 16'd1;
            held_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            held_reg  <= held_next;
        end
    end

    // Prefix buffer of the identifier being scanned.
    always_ff @(posedge aclk) begin
        if (accept && pre_we) pre_reg[pre_wa] <= pre_wd;
    end

    stt_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept && set.count != 2'd0),
        .set_in   (set),
        .can_push (can_push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tok    (m_tok),
        .m_last   (m_tlast)
    );

    assign m_tdata = {2'b00, m_tok.line, m_tok.len, m_tok.start, m_tok.kind};

    `STT_ASSERT(a_pos_cap, aclk, aresetn, pos_reg <= POS_CAP)
    `STT_ASSERT(a_line_nz, aclk, aresetn, line_reg != 16'd0)
    `STT_ASSERT(a_eof_reset, aclk, aresetn, (accept && s_tuser) |=> (pos_reg == 16'd0 && mode_reg == M_IDLE))

endmodule

// ===== tb/sv/source_text_tokenizer_test.sv =====
// Self-checking testbench for the streaming source text tokenizer.
module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int POS_LIMIT = 65535;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    source_text_tokenizer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    // Scanner shadow state
    scan_mode_t  sh_mode;
    logic [15:0] sh_pos, sh_start, sh_line;
    logic [7:0]  sh_prefix [8];
    logic [7:0]  sh_held;

    // Expected tokens: kind, start, length, line, last
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } exp_token_t;

    exp_token_t  token_queue [$];
    text_item_t  text_queue [$];
    int          step_tokens;
    int          fail_count = 0;
    int          tokens_seen = 0;
    int          items_sent = 0;
    int          send_idle_pct = 25, recv_idle_pct = 47;
    int          hold_cycles = 0;
    logic        stimulus_done = 1'b0;

    function automatic bit alpha_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_scanner();
        sh_mode = M_IDLE;
        sh_pos = '0;
        sh_start = '0;
        sh_line = 16'd1;
        sh_held = '0;
        for (int i = 0; i < 8; i++) sh_prefix[i] = '0;
    endtask

    function automatic void bump_pos();
        if (sh_pos < POS_LIMIT) sh_pos++;
    endfunction

    function automatic void push_token(logic [5:0] k, logic [15:0] st, logic [15:0] ln);
        exp_token_t t;
        if (step_tokens < MAX_RES) begin
            t = '{kind: k, start: st, len: ln, line: sh_line, last: 1'b0};
            token_queue.push_back(t);
            step_tokens++;
        end
    endfunction

    function automatic void push_span(logic [5:0] k);
        push_token(k, sh_start, sh_pos - sh_start);
    endfunction

    function automatic logic [5:0] operator_code(logic [7:0] c);
        case (c)
            "-": return K_MINUS;
            "+": return K_PLUS;
            "/": return K_SLASH;
            "*": return K_STAR;
            "%": return K_PERCENT;
            "!": return K_BANG;
            "=": return K_EQUAL;
            "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic bit prefix_is(string w, int n);
        if (w.len() != n) return 0;
        for (int i = 0; i < n; i++) if (sh_prefix[i] != w[i]) return 0;
        return 1;
    endfunction

    function automatic logic [5:0] word_code();
        int n;
        n = sh_pos - sh_start;
        if (n > 8) return K_IDENT;
        if (prefix_is("and", n)) return K_AND;
        if (prefix_is("break", n)) return K_BREAK;
        if (prefix_is("case", n)) return K_CASE;
        if (prefix_is("class", n)) return K_CLASS;
        if (prefix_is("continue", n)) return K_CONTINUE;
        if (prefix_is("default", n)) return K_DEFAULT;
        if (prefix_is("else", n)) return K_ELSE;
        if (prefix_is("false", n)) return K_FALSE;
        if (prefix_is("for", n)) return K_FOR;
        if (prefix_is("fun", n)) return K_FUN;
        if (prefix_is("if", n)) return K_IF;
        if (prefix_is("nil", n)) return K_NIL;
        if (prefix_is("or", n)) return K_OR;
        if (prefix_is("print", n)) return K_PRINT;
        if (prefix_is("return", n)) return K_RETURN;
        if (prefix_is("super", n)) return K_SUPER;
        if (prefix_is("switch", n)) return K_SWITCH;
        if (prefix_is("this", n)) return K_THIS;
        if (prefix_is("true", n)) return K_TRUE;
        if (prefix_is("var", n)) return K_VAR;
        if (prefix_is("while", n)) return K_WHILE;
        return K_IDENT;
    endfunction

    // Number then the held dot as its own token
    function automatic void split_dot();
        push_span(K_NUMBER);
        sh_start = sh_pos;
        bump_pos();
        push_span(K_DOT);
    endfunction

    task automatic scan_fresh(logic [7:0] c);
        if (c == " " || c == 8'h0d || c == 8'h09) begin
            bump_pos();
        end else if (c == 8'h0a) begin
            if (sh_line < 16'hffff) sh_line++;
            bump_pos();
        end else begin
            sh_start = sh_pos;
            bump_pos();
            if (alpha_ch(c)) begin
                sh_prefix[0] = c;
                sh_mode = M_IDENT;
            end else if (digit_ch(c)) begin
                sh_mode = M_NUM;
            end else begin
                case (c)
                    "\"": sh_mode = M_STR;
                    "/": sh_mode = M_SLASH;
                    "-", "+", "*", "%", "!", "=", "<", ">": begin
                        sh_held = c;
                        sh_mode = M_OP;
                    end
                    "(": push_span(K_LPAREN);
                    ")": push_span(K_RPAREN);
                    "{": push_span(K_LBRACE);
                    "}": push_span(K_RBRACE);
                    ";": push_span(K_SEMI);
                    ":": push_span(K_COLON);
                    ",": push_span(K_COMMA);
                    ".": push_span(K_DOT);
                    default: push_span(K_ERR_CHAR);
                endcase
            end
        end
    endtask

    // Continue the token in progress; return 1 when the byte must be rescanned
    function automatic bit scan_continue(logic [7:0] c);
        int n;
        case (sh_mode)
            M_IDENT: begin
                if (alpha_ch(c) || digit_ch(c)) begin
                    n = sh_pos - sh_start;
                    if (n < 8) sh_prefix[n] = c;
                    bump_pos();
                    return 0;
                end
                push_span(word_code());
                return 1;
            end
            M_NUM: begin
                if (digit_ch(c)) begin
                    bump_pos();
                    return 0;
                end
                if (c == ".") begin
                    sh_mode = M_NUMDOT;
                    return 0;
                end
                push_span(K_NUMBER);
                return 1;
            end
            M_NUMDOT: begin
                if (digit_ch(c)) begin
                    bump_pos();
                    bump_pos();
                    sh_mode = M_FRAC;
                    return 0;
                end
                split_dot();
                return 1;
            end
            M_FRAC: begin
                if (digit_ch(c)) begin
                    bump_pos();
                    return 0;
                end
                push_span(K_NUMBER);
                return 1;
            end
            M_STR: begin
                bump_pos();
                if (c == "\"") begin
                    push_span(K_STRING);
                    sh_mode = M_IDLE;
                end else if (c == 8'h0a && sh_line < 16'hffff) begin
                    sh_line++;
                end
                return 0;
            end
            M_CMT: begin
                if (c == 8'h0a) return 1;
                bump_pos();
                return 0;
            end
            M_SLASH: begin
                if (c == "/") begin
                    bump_pos();
                    sh_mode = M_CMT;
                    return 0;
                end
                if (c == "=") begin
                    bump_pos();
                    push_span(K_SLASH_EQ);
                    sh_mode = M_IDLE;
                    return 0;
                end
                push_span(K_SLASH);
                return 1;
            end
            M_OP: begin
                if (c == "=") begin
                    bump_pos();
                    push_span(operator_code(sh_held) + 6'd1);
                    sh_mode = M_IDLE;
                    return 0;
                end
                push_span(operator_code(sh_held));
                return 1;
            end
            default: return 1;
        endcase
    endfunction

    // Work out the tokens that one accepted item causes
    task automatic predict_tokens(text_item_t it);
        step_tokens = 0;
        if (it.fin) begin
            case (sh_mode)
                M_IDENT: push_span(word_code());
                M_NUM, M_FRAC: push_span(K_NUMBER);
                M_NUMDOT: split_dot();
                M_STR: push_span(K_ERR_STR);
                M_SLASH: push_span(K_SLASH);
                M_OP: push_span(operator_code(sh_held));
                default: ;
            endcase
            push_token(K_EOF, sh_pos, 16'd0);
            clear_scanner();
        end else if (sh_mode == M_IDLE || scan_continue(it.ch)) begin
            sh_mode = M_IDLE;
            scan_fresh(it.ch);
        end
        if (step_tokens > 0) token_queue[$].last = 1'b1;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) text_queue.push_back('{ch: s[i], fin: 1'b0});
    endtask

    task automatic add_end();
        text_queue.push_back('{ch: 8'($urandom), fin: 1'b1});
    endtask

    // Random source fragments, mostly well-formed
    task automatic add_fragment();
        string words [] = '{"and", "break", "case", "class", "continue", "default", "else",
            "false", "for", "fun", "if", "nil", "or", "print", "return", "super", "switch",
            "this", "true", "var", "while", "x_1", "continuex", "Zeta", "_a9b8c7d6e"};
        string ops [] = '{"(", ")", "{", "}", ";", ":", ",", ".", "-", "-=", "+", "+=",
            "/", "/=", "*", "*=", "%", "%=", "!", "!=", "=", "==", "<", "<=", ">", ">="};
        case ($urandom_range(0, 9))
            0, 1: add_text(words[$urandom_range(0, words.size() - 1)]);
            2, 3: add_text(ops[$urandom_range(0, ops.size() - 1)]);
            4: begin
                for (int i = $urandom_range(0, 3); i >= 0; i--)
                    text_queue.push_back('{ch: 8'("0" + $urandom_range(0, 9)), fin: 1'b0});
                if ($urandom_range(0, 1)) add_text($urandom_range(0, 1) ? ".5" : ".");
            end
            5: add_text($urandom_range(0, 1) ? "\"ab\ncd\"" : "\"x\"");
            6: add_text("// note\n");
            7: add_text($urandom_range(0, 1) ? "\n" : " \t\r");
            default: text_queue.push_back('{ch: 8'($urandom), fin: 1'b0});
        endcase
        if ($urandom_range(0, 2) == 0) add_text(" ");
    endtask

    // Offer items from the pending queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_tokens('{ch: s_tdata, fin: s_tuser});
                items_sent++;
            end
            if ((!s_tvalid || s_tready) ) begin
                if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata <= text_queue[0].ch;
                    s_tuser <= text_queue[0].fin;
                    s_tvalid <= 1'b1;
                    text_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take tokens and compare against the oldest expectation
    always @(posedge aclk) begin
        exp_token_t want, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{kind: m_tdata[5:0], start: m_tdata[21:6], len: m_tdata[37:22],
                        line: m_tdata[53:38], last: m_tlast};
                tokens_seen++;
                if (token_queue.size() == 0) begin
                    $display("%0t: token with none expected, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = token_queue.pop_front();
                    if (got != want) begin
                        $display("%0t: token mismatch expected k=%0d s=%0d l=%0d ln=%0d t=%0b",
                            $time, want.kind, want.start, want.len, want.line, want.last);
                        $display("%0t:                actual   k=%0d s=%0d l=%0d ln=%0d t=%0b",
                            $time, got.kind, got.start, got.len, got.line, got.last);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        clear_scanner();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: keywords, operators, numbers, strings, comments, errors
        add_text("and break case class continue default else false for fun if nil or\n");
        add_text("print return super switch this true var while continues x\n");
        add_end();
        add_text("(){};:,.- -=+ +=/ /=* *=% %=! !== ==< <=> >=");
        add_end();
        add_text("12.5 7. 3.x 9");
        add_end();
        add_text("\"a\nb\" // c\n@");
        text_queue.push_back('{ch: 8'h00, fin: 1'b0});
        text_queue.push_back('{ch: 8'hff, fin: 1'b0});
        add_text("\"open");
        add_end();
        add_text("4.");
        add_end();
        add_text("x /");
        add_end();
        add_text("<");
        add_end();
        add_end();

        // Random source texts, three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < 38; ) begin
                int before_n;
                before_n = text_queue.size();
                add_fragment();
                k += text_queue.size() - before_n;
                if ($urandom_range(0, 15) == 0) add_end();
            end
            add_end();
            if (ph == 0) begin
                wait (text_queue.size() < 60);
                @(posedge aclk);
                hold_cycles <= 150;
            end
            wait (text_queue.size() == 0);
            @(posedge aclk);
            while (s_tvalid) @(posedge aclk);
            if (ph == 0) begin
                send_idle_pct = 47;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        while (token_queue.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Scanned %0d source items into %0d tokens across keywords, operators,",
            items_sent, tokens_seen);
        $display("numbers, strings, comments, errors and end markers under back-pressure.");
        if (fail_count == 0 && token_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
